// File: rtl/core/shell_profile_evaluator_macros.svh
// ----------------------------------------------------------------------------
// Shell profile evaluator assertion macros
// Concurrent assertion wrappers clocked on clk_i, used by the checker.
// ----------------------------------------------------------------------------
`ifndef SHELL_PROFILE_EVALUATOR_MACROS_SVH
`define SHELL_PROFILE_EVALUATOR_MACROS_SVH

// Checked only out of reset.
`define SPE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("shell profile evaluator: assertion failed");

// Checked during reset as well.
`define SPE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("shell profile evaluator: reset assertion failed");

`endif

// File: rtl/core/spe_pkg.sv
// ----------------------------------------------------------------------------
// Shell profile evaluator package
// Codes, pipeline payload types, Horner constants and step functions.
// ----------------------------------------------------------------------------
`default_nettype none

package spe_pkg;

  localparam int unsigned SPE_ANGLE_W_DEF = 32;

  // register indexes
  localparam logic [1:0] SPE_CFG_MODE  = 2'd0;
  localparam logic [1:0] SPE_CFG_INNER = 2'd1;
  localparam logic [1:0] SPE_CFG_OUTER = 2'd2;
  localparam logic [1:0] SPE_CFG_NORM  = 2'd3;

  // region codes
  localparam logic [1:0] SPE_REG_OUT   = 2'd0;
  localparam logic [1:0] SPE_REG_WALL  = 2'd1;
  localparam logic [1:0] SPE_REG_INNER = 2'd2;

  localparam logic [31:0] SPE_PI   = 32'd3373259426;
  localparam logic [31:0] SPE_PI2  = 32'd1686629713;
  localparam logic [30:0] SPE_ONE  = 31'h4000_0000;
  localparam logic [47:0] SPE_MAX48 = 48'hFFFF_FFFF_FFFF;

  localparam int unsigned SPE_HRN_STEPS = 9;

  // k(k+1) divisors of the sine series, innermost first
  localparam logic [8:0] SPE_HRN_DEN [SPE_HRN_STEPS] = '{
    9'd342, 9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6
  };

  // floor(2^36 / den)
  localparam logic [33:0] SPE_HRN_RECIP [SPE_HRN_STEPS] = '{
    34'((64'd1 << 36) / 64'd342), 34'((64'd1 << 36) / 64'd272),
    34'((64'd1 << 36) / 64'd210), 34'((64'd1 << 36) / 64'd156),
    34'((64'd1 << 36) / 64'd110), 34'((64'd1 << 36) / 64'd72),
    34'((64'd1 << 36) / 64'd42),  34'((64'd1 << 36) / 64'd20),
    34'((64'd1 << 36) / 64'd6)
  };

  typedef struct packed {
    logic [30:0] u;
    logic [31:0] u2;
    logic [31:0] xs;
    logic [30:0] r;
    logic [31:0] q;
    logic [29:0] qh;
  } hrn_t;

  typedef struct packed {
    logic [1:0]  region;
    logic [31:0] d_o;
    logic [31:0] d_i;
    logic [31:0] rem_o;
    logic [29:0] root_o;
    logic [31:0] rem_i;
    logic [29:0] root_i;
  } sqr_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [29:0] root;
  } sq_bit_t;

  // q = floor(u2 * r / 2^30)
  function automatic hrn_t spe_hrn_mul(hrn_t s);
    hrn_t        o;
    logic [62:0] p;
    o   = s;
    p   = 63'(s.u2) * 63'(s.r);
    o.q = p[61:30];
    return o;
  endfunction

  // estimate of q / den, low by at most one
  function automatic hrn_t spe_hrn_div(hrn_t s, logic [33:0] m);
    hrn_t        o;
    logic [65:0] p;
    o    = s;
    p    = 66'(s.q) * 66'(m);
    o.qh = p[65:36];
    return o;
  endfunction

  // correct the estimate, then r = 1 - q / den
  function automatic hrn_t spe_hrn_fix(hrn_t s, logic [8:0] den);
    hrn_t        o;
    logic [32:0] rem;
    logic [30:0] qf;
    o   = s;
    rem = 33'(s.q) - 33'(s.qh) * 33'(den);
    qf  = 31'(s.qh) + ((rem >= 33'(den)) ? 31'd1 : 31'd0);
    o.r = SPE_ONE - qf;
    return o;
  endfunction

  // one root bit of a restoring square root
  function automatic sq_bit_t spe_sqrt_bit(logic [31:0] rem, logic [29:0] root,
                                           logic [1:0] pair);
    sq_bit_t     o;
    logic [33:0] r4;
    logic [33:0] trial;
    r4    = {rem, pair};
    trial = {2'b00, root, 2'b01};
    if (r4 >= trial) begin
      o.rem  = 32'(r4 - trial);
      o.root = {root[28:0], 1'b1};
    end else begin
      o.rem  = 32'(r4);
      o.root = {root[28:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/spe_in_if.sv
// ----------------------------------------------------------------------------
// Shell profile evaluator input channel
// Valid/ready channel carrying one separation angle per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface spe_in_if #(
  parameter int unsigned ANGLE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [ANGLE_WIDTH-1:0] separation_angle;

  modport source (output valid, output separation_angle, input ready);
  modport sink   (input valid, input separation_angle, output ready);
endinterface

`default_nettype wire

// File: rtl/core/spe_out_if.sv
// ----------------------------------------------------------------------------
// Shell profile evaluator output channel
// Valid/ready channel carrying one profile result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface spe_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] profile_value;
  logic [1:0]  region;
  logic        saturated;

  modport source (output valid, output profile_value, output region, output saturated,
                  input ready);
  modport sink   (input valid, input profile_value, input region, input saturated,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/shell_profile_evaluator.sv
// ----------------------------------------------------------------------------
// Shell profile evaluator
// Radial profile of a spherical shell, one result per angle, fully pipelined.
// ----------------------------------------------------------------------------
// One result per angle transfer, in order. Throughput is one angle per clock
// while no result waits unaccepted at the output. The depth is set by the
// sine path (nine Horner steps of three stages each: multiply, reciprocal
// multiply, correction) and by the two 30-stage bit-per-stage square roots
// that run side by side. The whole pipe moves on a single enable: it stalls
// only while a result sits unaccepted at the output, and with the output
// empty the input is always ready. Registers may be written only while the
// pipe is empty; the stages that use them read them live.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_profile_evaluator #(
  parameter int unsigned ANGLE_WIDTH = spe_pkg::SPE_ANGLE_W_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  spe_in_if.sink           in_i,
  spe_out_if.source        out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_data_i
);
  import spe_pkg::*;

  localparam int unsigned HRN_STAGES = 3 * SPE_HRN_STEPS;
  localparam int unsigned SQ_STEPS   = 30;
  // entry, square, Horner, sine, x select, compare, roots, diff, mult, out
  localparam int unsigned LAT        = 2 + HRN_STAGES + 3 + SQ_STEPS + 3;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        mode_q;
  logic [31:0] inner_q;
  logic [31:0] outer_q;
  logic [47:0] norm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b1;
      inner_q <= '0;
      outer_q <= '0;
      norm_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        SPE_CFG_MODE:  mode_q  <= cfg_data_i[0];
        SPE_CFG_INNER: inner_q <= cfg_data_i[31:0];
        SPE_CFG_OUTER: outer_q <= cfg_data_i[31:0];
        SPE_CFG_NORM:  norm_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: one enable for every stage, valid bits shift alongside
  // --------------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en         = ~vld_q[LAT-1] | out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // --------------------------------------------------------------------------
  // Entry stage: angle to Q2.30, fold into [0, pi/2] for the sine path
  // --------------------------------------------------------------------------
  logic [31:0] t_in;
  logic [30:0] u_in;

  if (ANGLE_WIDTH >= 32) begin : g_trunc
    assign t_in = in_i.separation_angle[ANGLE_WIDTH-1 -: 32];
  end else begin : g_pad
    assign t_in = {in_i.separation_angle, {(32-ANGLE_WIDTH){1'b0}}};
  end

  // sin^2 is symmetric about pi/2 and periodic in pi
  always_comb begin
    if (t_in <= SPE_PI2) begin
      u_in = t_in[30:0];
    end else if (t_in <= SPE_PI) begin
      u_in = 31'(SPE_PI - t_in);
    end else begin
      u_in = 31'(t_in - SPE_PI);
    end
  end

  logic [31:0] t0_q;
  logic [30:0] u0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_q <= t_in;
      u0_q <= u_in;
    end
  end

  // --------------------------------------------------------------------------
  // Squares: u^2 in Q2.30 for the series, theta^2 in Q4.28 for small angles
  // --------------------------------------------------------------------------
  logic [61:0] uu;
  logic [64:0] tt;
  logic [30:0] u1_q;
  logic [31:0] u2_1_q;
  logic [31:0] xs1_q;

  assign uu = 62'(u0_q) * 62'(u0_q);
  assign tt = 65'(t0_q) * 65'(t0_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q   <= u0_q;
      u2_1_q <= 32'((uu + 62'd536870912) >> 30);
      xs1_q  <= 32'((tt + 65'd2147483648) >> 32);
    end
  end

  // --------------------------------------------------------------------------
  // Horner series for sin(u)/u, three stages per term
  // --------------------------------------------------------------------------
  hrn_t hrn_seed;
  hrn_t hrn_d [HRN_STAGES];
  hrn_t hrn_q [HRN_STAGES];

  always_comb begin
    hrn_seed    = '0;
    hrn_seed.u  = u1_q;
    hrn_seed.u2 = u2_1_q;
    hrn_seed.xs = xs1_q;
    hrn_seed.r  = SPE_ONE;
  end

  for (genvar k = 0; k < SPE_HRN_STEPS; k++) begin : g_hrn
    hrn_t prev;
    if (k == 0) begin : g_first
      assign prev = hrn_seed;
    end else begin : g_next
      assign prev = hrn_q[3*k-1];
    end
    assign hrn_d[3*k]   = spe_hrn_mul(prev);
    assign hrn_d[3*k+1] = spe_hrn_div(hrn_q[3*k], SPE_HRN_RECIP[k]);
    assign hrn_d[3*k+2] = spe_hrn_fix(hrn_q[3*k+1], SPE_HRN_DEN[k]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < HRN_STAGES; i++) begin
        hrn_q[i] <= hrn_d[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // sin = u * r, then x = sin^2 rounded to Q4.28, mode picks the x in use
  // --------------------------------------------------------------------------
  logic [61:0] sin_prod;
  logic [30:0] sin_q;
  logic [31:0] xs2_q;
  logic [61:0] sin_sq;
  logic [31:0] x_q;

  assign sin_prod = 62'(hrn_q[HRN_STAGES-1].u) * 62'(hrn_q[HRN_STAGES-1].r);
  assign sin_sq   = 62'(sin_q) * 62'(sin_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sin_q <= sin_prod[60:30];
      xs2_q <= hrn_q[HRN_STAGES-1].xs;
      x_q   <= mode_q ? xs2_q : 32'((63'(sin_sq) + 63'd2147483648) >> 32);
    end
  end

  // --------------------------------------------------------------------------
  // Region decision and radicands; unused radicands are zeroed so their
  // roots come out zero
  // --------------------------------------------------------------------------
  sqr_t cmp_d;

  always_comb begin
    cmp_d = '0;
    if (x_q < outer_q) begin
      cmp_d.region = SPE_REG_WALL;
      cmp_d.d_o    = outer_q - x_q;
      if (x_q < inner_q) begin
        cmp_d.region = SPE_REG_INNER;
        cmp_d.d_i    = inner_q - x_q;
      end
    end else begin
      cmp_d.region = SPE_REG_OUT;
    end
  end

  sqr_t cmp_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmp_q <= cmp_d;
    end
  end

  // --------------------------------------------------------------------------
  // Two square roots of d * 2^28, one result bit per stage, MSB first
  // --------------------------------------------------------------------------
  sqr_t sq_d [SQ_STEPS];
  sqr_t sq_q [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    localparam int unsigned BI = SQ_STEPS - 1 - j;
    sqr_t       prev;
    logic [1:0] pr_o;
    logic [1:0] pr_i;
    sq_bit_t    bo;
    sq_bit_t    bi;

    if (j == 0) begin : g_first
      assign prev = cmp_q;
    end else begin : g_next
      assign prev = sq_q[j-1];
    end

    // low 28 bits of the radicand are zero
    if (BI >= 14) begin : g_data
      assign pr_o = prev.d_o[2*BI-27 -: 2];
      assign pr_i = prev.d_i[2*BI-27 -: 2];
    end else begin : g_zero
      assign pr_o = 2'b00;
      assign pr_i = 2'b00;
    end

    assign bo = spe_sqrt_bit(prev.rem_o, prev.root_o, pr_o);
    assign bi = spe_sqrt_bit(prev.rem_i, prev.root_i, pr_i);

    always_comb begin
      sq_d[j]        = prev;
      sq_d[j].rem_o  = bo.rem;
      sq_d[j].root_o = bo.root;
      sq_d[j].rem_i  = bi.rem;
      sq_d[j].root_i = bi.root;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < SQ_STEPS; i++) begin
        sq_q[i] <= sq_d[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Wall thickness, clamped at zero for an inner bound above the outer one
  // --------------------------------------------------------------------------
  logic [29:0] ro;
  logic [29:0] ri;
  logic [29:0] val_q;
  logic [1:0]  reg_v_q;

  assign ro = sq_q[SQ_STEPS-1].root_o;
  assign ri = sq_q[SQ_STEPS-1].root_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q   <= (ro > ri) ? (ro - ri) : '0;
      reg_v_q <= sq_q[SQ_STEPS-1].region;
    end
  end

  // --------------------------------------------------------------------------
  // Norm product in two halves, then sum, shift and saturate
  // --------------------------------------------------------------------------
  logic [53:0] a_q;
  logic [53:0] b_q;
  logic [1:0]  reg_m_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q     <= 54'(val_q) * 54'(norm_q[47:24]);
      b_q     <= 54'(val_q) * 54'(norm_q[23:0]);
      reg_m_q <= reg_v_q;
    end
  end

  logic [78:0] total;
  logic [50:0] prod;
  logic        ovf;
  logic [47:0] prof_q;
  logic [1:0]  reg_o_q;
  logic        sat_q;

  assign total = {1'b0, a_q, 24'b0} + 79'(b_q);
  assign prod  = total[78:28];
  assign ovf   = |prod[50:48];

  always_ff @(posedge clk_i) begin
    if (en) begin
      prof_q  <= ovf ? SPE_MAX48 : prod[47:0];
      sat_q   <= ovf;
      reg_o_q <= reg_m_q;
    end
  end

  assign out_o.valid         = vld_q[LAT-1];
  assign out_o.profile_value = prof_q;
  assign out_o.region        = reg_o_q;
  assign out_o.saturated     = sat_q;

endmodule

`default_nettype wire

// File: rtl/core/spe_checker.sv
// ----------------------------------------------------------------------------
// Shell profile evaluator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shell_profile_evaluator_macros.svh"

module spe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [47:0] profile_value_i,
  input wire logic [1:0]  region_i,
  input wire logic        saturated_i
);
  import spe_pkg::*;

  // a waiting result holds
  `SPE_ASSERT(a_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(profile_value_i))
  // an empty output never blocks the input
  `SPE_ASSERT(a_drain, !out_valid_i |-> in_ready_i)
  // outside the shell: zero, never saturated
  `SPE_ASSERT(a_outside, out_valid_i && region_i == SPE_REG_OUT |-> profile_value_i == 48'd0 && !saturated_i)
  // saturation pins the value at full scale
  `SPE_ASSERT(a_sat, out_valid_i && saturated_i |-> profile_value_i == SPE_MAX48 && region_i != SPE_REG_OUT)
  // nothing offered while in reset
  `SPE_ASSERT_RST(a_rst, !rst_ni |-> !out_valid_i)

endmodule

bind shell_profile_evaluator spe_checker u_spe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .profile_value_i (out_o.profile_value),
  .region_i        (out_o.region),
  .saturated_i     (out_o.saturated)
);

`default_nettype wire

// File: verif/tb_shell_profile_evaluator.sv
// ----------------------------------------------------------------------------
// Shell profile evaluator testbench
// Drives angle transfers under random idling, predicts bit for bit each result
// not typed into a table, checks all field by field against output transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_shell_profile_evaluator;
  import spe_pkg::*;

  localparam int unsigned LAT       = 65;
  localparam longint      CYCLE_CAP = 400000;
  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] HALF_PI   = 64'd1686629713;
  localparam logic [63:0] ONE_Q30   = 64'd1 << 30;

  typedef struct packed {
    logic [47:0] profile_value;
    logic [1:0]  region;
    logic        saturated;
  } profile_t;

  // one row of the directed table; has_exp marks rows whose result is typed in
  typedef struct {
    logic [31:0] angle;
    bit          has_exp;
    profile_t    exp;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [47:0] cfg_data_i;

  spe_in_if  #(.ANGLE_WIDTH(32)) in_ch ();
  spe_out_if                     out_ch ();

  shell_profile_evaluator #(.ANGLE_WIDTH(32)) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // shadow copy of the block's registers
  logic        mode_q;
  logic [31:0] inner_q;
  logic [31:0] outer_q;
  logic [47:0] norm_q;

  profile_t pending_profiles[$];
  int       errors;
  longint   cycles;
  bit       idle_free;  // stretch with no idling on either side

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("tb_shell_profile_evaluator failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // sin^2 of a Q2.30 angle, Q4.28, via folded Taylor series
  function automatic logic [63:0] sin_sq(logic [63:0] t);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] r;
    logic [63:0] den[9];
    den = '{342, 272, 210, 156, 110, 72, 42, 20, 6};
    if (t <= HALF_PI)     u = t;
    else if (t <= PI_Q30) u = PI_Q30 - t;
    else                  u = t - PI_Q30;
    u2 = (u * u + (64'd1 << 29)) >> 30;
    r  = ONE_Q30;
    for (int k = 0; k < 9; k++) r = ONE_Q30 - (((u2 * r) >> 30) / den[k]);
    r = (u * r) >> 30;
    return (r * r + (64'd1 << 31)) >> 32;
  endfunction

  function automatic profile_t shell_profile(logic [31:0] angle);
    profile_t    p;
    logic [63:0] t, x, val, sub, a, b, prod;
    t   = 64'(angle);
    val = 0;
    p   = '0;
    p.region = SPE_REG_OUT;
    x = mode_q ? ((t * t + (64'd1 << 31)) >> 32) : sin_sq(t);
    if (x < 64'(outer_q)) begin
      p.region = SPE_REG_WALL;
      val = isqrt((64'(outer_q) - x) << 28);
      if (x < 64'(inner_q)) begin
        sub      = isqrt((64'(inner_q) - x) << 28);
        p.region = SPE_REG_INNER;
        val      = (val > sub) ? val - sub : 64'd0;
      end
    end
    if (val != 0) begin
      a    = val * (64'(norm_q) >> 24);
      b    = val * (64'(norm_q) & 64'hFF_FFFF);
      prod = (a >> 4) + ((((a & 64'd15) << 24) + b) >> 28);
      if (prod > 64'(SPE_MAX48)) begin
        p.profile_value = SPE_MAX48;
        p.saturated     = 1'b1;
      end else begin
        p.profile_value = prod[47:0];
      end
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stalls, compare with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_profiles.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          profile_t e;
          e = pending_profiles.pop_front();
          if (out_ch.profile_value !== e.profile_value) begin
            $error("profile_value exp %0h got %0h", e.profile_value, out_ch.profile_value);
            errors++;
          end
          if (out_ch.region !== e.region) begin
            $error("region exp %0d got %0d", e.region, out_ch.region);
            errors++;
          end
          if (out_ch.saturated !== e.saturated) begin
            $error("saturated exp %0b got %0b", e.saturated, out_ch.saturated);
            errors++;
          end
        end
      end
      out_ch.ready <= idle_free || ($urandom_range(99) >= 19);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // one register write; the write enable is dropped again before the task returns
  task automatic write_reg(logic [1:0] idx, logic [47:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      SPE_CFG_MODE:  mode_q  = data[0];
      SPE_CFG_INNER: inner_q = data[31:0];
      SPE_CFG_OUTER: outer_q = data[31:0];
      SPE_CFG_NORM:  norm_q  = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_shell(logic mode, logic [31:0] inner, logic [31:0] outer,
                           logic [47:0] norm);
    write_reg(SPE_CFG_MODE, {47'd0, mode});
    write_reg(SPE_CFG_INNER, {16'd0, inner});
    write_reg(SPE_CFG_OUTER, {16'd0, outer});
    write_reg(SPE_CFG_NORM, norm);
  endtask

  // one angle transfer; valid held across back-to-back transfers
  task automatic send_angle(logic [31:0] angle, bit has_exp, profile_t exp);
    while (!idle_free && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid            <= 1'b1;
    in_ch.separation_angle <= angle;
    pending_profiles.insert(pending_profiles.size(),
                            has_exp ? exp : shell_profile(angle));
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_profiles.size() != 0) @(posedge clk_i);
    repeat (LAT) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(3))
      0:       return $urandom();                       // full range, above pi too
      1:       return $urandom_range(32'd3373259426);
      2:       return $urandom_range(32'h0800_0000);    // small angles
      default: return HALF_PI[31:0] + $urandom_range(255) - 128;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    row_t     rows[$];
    profile_t z;
    errors    = 0;
    idle_free = 1'b0;
    rst_ni    = 1'b1;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = SPE_CFG_MODE;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.separation_angle = '0;
    mode_q = 1'b1; inner_q = '0; outer_q = '0; norm_q = '0;
    z = '0;
    #1;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset the outer bound is zero: everything lies outside
    rows.insert(rows.size(), row_t'{32'd0, 1'b1, z});
    rows.insert(rows.size(), row_t'{32'hFFFF_FFFF, 1'b1, z});
    foreach (rows[i]) send_angle(rows[i].angle, rows[i].has_exp, rows[i].exp);
    drain();

    // maximal outer bound and norm, zero inner bound: product saturates at the centre
    set_shell(1'b1, 32'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    rows.delete();
    rows.insert(rows.size(),
                row_t'{32'd0, 1'b1, profile_t'{SPE_MAX48, SPE_REG_WALL, 1'b1}});
    rows.insert(rows.size(), row_t'{32'd1, 1'b0, z});
    rows.insert(rows.size(), row_t'{32'h8000_0000, 1'b0, z});
    rows.insert(rows.size(), row_t'{32'hFFFF_FFFF, 1'b0, z});
    foreach (rows[i]) send_angle(rows[i].angle, rows[i].has_exp, rows[i].exp);
    drain();

    // sine mode around the fold points, inner above outer (clamp to zero)
    set_shell(1'b0, 32'h2000_0000, 32'h0800_0000, 48'h00_0001_000000);
    rows.delete();
    foreach (rows[i]) ;
    for (int i = 0; i < 10; i++) begin
      logic [31:0] a;
      case (i)
        0: a = 0;                     1: a = HALF_PI[31:0];
        2: a = HALF_PI[31:0] + 1;     3: a = PI_Q30[31:0];
        4: a = PI_Q30[31:0] + 1;      5: a = 32'hFFFF_FFFF;
        6: a = 32'h0100_0000;         7: a = PI_Q30[31:0] - 32'h0100_0000;
        8: a = 32'h5555_5555;         default: a = 32'hAAAA_AAAA;
      endcase
      send_angle(a, 1'b0, z);
    end
    drain();

    // random part over several shells, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_shell(1'b1, 32'h0100_0000, 32'h1000_0000, 48'h00_0001_000000);
        1: set_shell(1'b0, 32'h0400_0000, 32'h1000_0000, 48'hFFFF_FFFF_FFFF);
        2: set_shell(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h0);
        3: set_shell(1'b0, 32'h0, 32'hFFFF_FFFF, 48'h00_0000_000001);
        default: set_shell($urandom_range(1), $urandom(), $urandom(),
                           48'({$urandom(), $urandom()}));
      endcase
      idle_free = (ph == 5);
      for (int n = 0; n < 80; n++) send_angle(rand_angle(), 1'b0, z);
      if (ph == 3) begin
        // hold off until the pipe is empty, then carry on
        in_ch.valid <= 1'b0;
        while (pending_profiles.size() != 0) @(posedge clk_i);
        for (int n = 0; n < 5; n++) send_angle(rand_angle(), 1'b0, z);
      end
      drain();
    end
    write_reg(SPE_CFG_MODE, 48'd1);

    if (errors == 0) begin
      $display("tb_shell_profile_evaluator passed");
    end else begin
      $display("tb_shell_profile_evaluator failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/spe_pkg.sv
rtl/core/spe_in_if.sv
rtl/core/spe_out_if.sv
rtl/core/shell_profile_evaluator.sv
rtl/core/spe_checker.sv
verif/tb_shell_profile_evaluator.sv
